// ----- hw/rtl/fdt_pkg.sv -----
// Package for the fragment depth test block: widths, register indexes, store
// geometry, controller states and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package fdt_pkg;

   // Store geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

   // Field widths
   localparam int DIM_W    = 9;
   localparam int COORD_W  = 16;
   localparam int WORD_W   = 32;
   localparam int PROD_W   = 2 * DIM_W + 1;
   localparam int CSR_IDX_W = 2;

   // Frame tags kept next to each stored depth
   localparam int EPOCH_W    = 4;
   localparam int MEM_WORD_W = EPOCH_W + WORD_W;

   // Reset values of the configuration registers
   localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RESET  = DIM_W'(256);
   localparam logic [DIM_W-1:0]  SCREEN_ROWS_RESET   = DIM_W'(256);
   localparam logic [WORD_W-1:0] FAR_DEPTH_RESET     = 32'hFFFF_FFFF;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_DEPTH     = 2'd2;

   // Opcodes
   localparam logic OP_FRAGMENT = 1'b0;
   localparam logic OP_COMMAND  = 1'b1;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_TEST
   } state_type;

   typedef struct packed {
      logic load_item;
      logic calc_index;
      logic mem_read;
      logic emit;
      logic store_write;
      logic new_frame;
      logic sweep_write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic item_is_cmd;
      logic frag_pass;
      logic out_full;
      logic epoch_last;
      logic sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fdt_req_if.sv -----
// Input channel of the fragment depth test block: valid, ready and one input word.
// Depends on fdt_pkg.
`default_nettype none

interface fdt_req_if;
   import fdt_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [WORD_W-1:0]   command_word;
   logic [COORD_W-1:0]  pixel_x;
   logic [COORD_W-1:0]  pixel_y;
   logic [WORD_W-1:0]   frag_depth;
   logic [WORD_W-1:0]   frag_color;

   modport source (output valid, opcode, command_word, pixel_x, pixel_y, frag_depth,
                   frag_color, input ready);
   modport sink   (input valid, opcode, command_word, pixel_x, pixel_y, frag_depth,
                   frag_color, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fdt_rsp_if.sv -----
// Result channel of the fragment depth test block: valid, ready and one result word.
// Depends on fdt_pkg.
`default_nettype none

interface fdt_rsp_if;
   import fdt_pkg::*;

   logic                valid;
   logic                ready;
   logic                is_command;
   logic [WORD_W-1:0]   out_command;
   logic [COORD_W-1:0]  out_x;
   logic [COORD_W-1:0]  out_y;
   logic [WORD_W-1:0]   out_color;

   modport source (output valid, is_command, out_command, out_x, out_y, out_color,
                   input ready);
   modport sink   (input valid, is_command, out_command, out_x, out_y, out_color,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fdt_csr_if.sv -----
// Configuration write channel of the fragment depth test block: valid, ready,
// register index and write data. Depends on fdt_pkg.
`default_nettype none

interface fdt_csr_if;
   import fdt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [WORD_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fdt_ctrl.sv -----
// Controller of the fragment depth test block: sequences accept, index, read,
// test and store sweep. Depends on fdt_pkg.
`default_nettype none

module fdt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  fdt_pkg::dp_status_type stat,
   output fdt_pkg::ctrl_cmd_type  cmd
);
   import fdt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_INDEX;
            end
         end
         ST_INDEX: begin
            cmd.calc_index = 1'b1;
            state_in       = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_TEST;
         end
         ST_TEST: begin
            if (!stat.item_is_cmd && !stat.frag_pass) begin
               // drop the fragment
               state_in = ST_IDLE;
            end else if (!stat.out_full) begin
               cmd.emit        = 1'b1;
               cmd.store_write = !stat.item_is_cmd;
               cmd.new_frame   = stat.item_is_cmd;
               state_in = (stat.item_is_cmd && stat.epoch_last) ? ST_SWEEP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fdt_datapath.sv -----
// Datapath of the fragment depth test block: configuration registers, item
// registers, index multiply, tagged depth store, compare and output register.
// Depends on fdt_pkg and the three channel interfaces.
`default_nettype none

module fdt_datapath (
   input  wire                    clock,
   input  wire                    reset,
   fdt_req_if.sink                req,
   fdt_rsp_if.source              rsp,
   fdt_csr_if.sink                csr,
   input  fdt_pkg::ctrl_cmd_type  cmd,
   output fdt_pkg::dp_status_type stat
);
   import fdt_pkg::*;

   // Configuration
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [WORD_W-1:0] far_depth_ff;

   // Frame state
   logic [EPOCH_W-1:0] epoch_ff;
   logic [WORD_W-1:0]  clear_depth_ff;
   logic [ADDR_W-1:0]  sweep_ff;

   // Item
   logic               opcode_ff;
   logic [WORD_W-1:0]  cmd_word_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;
   logic [WORD_W-1:0]  depth_ff;
   logic [WORD_W-1:0]  color_ff;
   logic               inb_ff;
   logic [ADDR_W-1:0]  addr_ff;

   // Store
   logic [MEM_WORD_W-1:0] mem [STORE_SIZE];
   logic [MEM_WORD_W-1:0] rd_ff;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [MEM_WORD_W-1:0] wr_word;

   // Output register
   logic               rsp_valid_ff;
   logic               is_cmd_ff;
   logic [WORD_W-1:0]  out_cmd_ff;
   logic [COORD_W-1:0] out_x_ff;
   logic [COORD_W-1:0] out_y_ff;
   logic [WORD_W-1:0]  out_color_ff;

   logic [DIM_W-1:0]   w_used;
   logic [DIM_W-1:0]   h_used;
   logic               inb_in;
   logic [PROD_W-1:0]  prod;
   logic [WORD_W-1:0]  stored_depth;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SCREEN_WIDTH_RESET;
         height_ff    <= SCREEN_ROWS_RESET;
         far_depth_ff <= FAR_DEPTH_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_SCREEN_WIDTH:  width_ff     <= csr.data[DIM_W-1:0];
            CSR_SCREEN_ROWS:   height_ff    <= csr.data[DIM_W-1:0];
            CSR_FAR_DEPTH:     far_depth_ff <= csr.data;
            default: begin
            end
         endcase
      end
   end

   // Clamp the screen to the store size
   always_comb begin
      w_used = (32'(width_ff) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_ff;
      h_used = (32'(height_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_ff;
      inb_in = (x_ff < COORD_W'(w_used)) && (y_ff < COORD_W'(h_used));
      prod   = PROD_W'(x_ff[DIM_W-1:0]) * PROD_W'(h_used) + PROD_W'(y_ff[DIM_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff       <= '0;
         clear_depth_ff <= FAR_DEPTH_RESET;
         sweep_ff       <= '0;
      end else begin
         if (cmd.new_frame) begin
            epoch_ff       <= epoch_ff + 1'b1;
            clear_depth_ff <= far_depth_ff;
         end
         if (cmd.sweep_write) begin
            sweep_ff <= stat.sweep_last ? '0 : sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         opcode_ff   <= req.opcode;
         cmd_word_ff <= req.command_word;
         x_ff        <= req.pixel_x;
         y_ff        <= req.pixel_y;
         depth_ff    <= req.frag_depth;
         color_ff    <= req.frag_color;
      end
      if (cmd.calc_index) begin
         inb_ff  <= inb_in;
         addr_ff <= ADDR_W'(prod);
      end
   end

   // Store: one write port, one registered read port
   always_comb begin
      wr_en   = cmd.sweep_write || cmd.store_write;
      wr_addr = cmd.sweep_write ? sweep_ff : addr_ff;
      wr_word = cmd.sweep_write ? {epoch_ff, clear_depth_ff} : {epoch_ff, depth_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[addr_ff];
      end
   end

   // An entry tagged with an older frame reads as the clear depth
   always_comb begin
      stored_depth = (rd_ff[MEM_WORD_W-1 -: EPOCH_W] == epoch_ff) ?
                     rd_ff[WORD_W-1:0] : clear_depth_ff;
      stat.item_is_cmd = (opcode_ff == OP_COMMAND);
      stat.frag_pass   = (opcode_ff == OP_FRAGMENT) && inb_ff && (depth_ff < stored_depth);
      stat.out_full    = rsp_valid_ff;
      stat.epoch_last  = (epoch_ff == '1);
      stat.sweep_last  = (sweep_ff == ADDR_W'(STORE_SIZE - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         is_cmd_ff    <= stat.item_is_cmd;
         out_cmd_ff   <= stat.item_is_cmd ? cmd_word_ff : '0;
         out_x_ff     <= stat.item_is_cmd ? '0 : x_ff;
         out_y_ff     <= stat.item_is_cmd ? '0 : y_ff;
         out_color_ff <= stat.item_is_cmd ? '0 : color_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.is_command  = is_cmd_ff;
   assign rsp.out_command = out_cmd_ff;
   assign rsp.out_x       = out_x_ff;
   assign rsp.out_y       = out_y_ff;
   assign rsp.out_color   = out_color_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fragment_depth_test.sv -----
// Top level of the fragment depth test block: joins controller and datapath.
// Depends on fdt_pkg, fdt_req_if, fdt_rsp_if, fdt_csr_if, fdt_ctrl, fdt_datapath.
//
// Depth-test ("less") stage of a rasterizer. Each word on req_ch is a fragment
// (opcode 0) or a pipeline command (opcode 1). A fragment inside the configured
// screen whose depth is strictly below the stored depth at x times the row count
// plus y updates the store and leaves on rsp_ch with its coordinates and color; any
// other fragment is dropped with no result. A command is forwarded on rsp_ch and
// starts a new frame: every store entry then reads as far_depth as it was when
// the command was taken. Each word passes through accept, index multiply, store
// read, and compare and write; the controller walks each word through these
// stages in turn and takes no new word until it is back in idle. A word with a
// result holds in the compare stage while the output register still holds an
// unread result.
// A result waits in an output register, so the next word can be accepted while
// it is still pending. Entries carry a 4-bit frame tag; every 16th command the
// tag wraps and the block runs a clearing pass over the whole store, one entry
// per cycle (65536 entries at the default store size), with req_ch.ready low. The
// same pass runs right after reset. csr_ch is always ready and may be written
// during a clearing pass; write it only while no word is in flight.
`default_nettype none

module fragment_depth_test (
   input  wire        clock,
   input  wire        reset,
   fdt_req_if.sink    req_ch,
   fdt_rsp_if.source  rsp_ch,
   fdt_csr_if.sink    csr_ch
);
   import fdt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;
   logic          req_ready;

   // Drive ready on the input channel from the controller
   assign req_ch.ready = req_ready;

   fdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fdt_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire

// ----- tb/fragment_depth_test_checker.sv -----
// Scoreboard for the fragment depth test block: tracks the register file and a
// private depth store, predicts each result and compares it with what leaves rsp_ch.
// Depends on fdt_pkg and the fdt_req_if, fdt_rsp_if and fdt_csr_if interfaces.

module fragment_depth_test_checker (
   input  wire  clock,
   input  wire  reset,
   fdt_req_if   req_ch,
   fdt_rsp_if   rsp_ch,
   fdt_csr_if   csr_ch,
   output int   error_count,
   output int   outstanding
);
   import fdt_pkg::*;

   typedef struct packed {
      logic                is_command;
      logic [WORD_W-1:0]   command;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [WORD_W-1:0]   color;
   } pixel_result_type;

   logic [DIM_W-1:0]   screen_w;
   logic [DIM_W-1:0]   screen_h;
   logic [WORD_W-1:0]  far_z;
   logic [WORD_W-1:0]  depth_mem [STORE_SIZE];
   pixel_result_type   expected_pixels [$];
   int                 errors = 0;

   assign error_count = errors;

   function automatic void fill_store(input logic [WORD_W-1:0] z);
      for (int i = 0; i < STORE_SIZE; i++) depth_mem[i] = z;
   endfunction

   // Run one accepted word through the depth test; queue a result if one leaves.
   function automatic void depth_test(input logic op, input logic [WORD_W-1:0] cmd,
                                      input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y,
                                      input logic [WORD_W-1:0] z,
                                      input logic [WORD_W-1:0] color);
      int unsigned      cols;
      int unsigned      rows;
      int unsigned      addr;
      pixel_result_type res;
      res = '0;
      cols = (screen_w > MAX_WIDTH) ? MAX_WIDTH : screen_w;
      rows = (screen_h > MAX_HEIGHT) ? MAX_HEIGHT : screen_h;
      if (op == OP_COMMAND) begin
         res.is_command = 1'b1;
         res.command = cmd;
         expected_pixels.push_back(res);
         fill_store(far_z);
      end else if (x < cols && y < rows) begin
         addr = x * rows + y;
         if (addr < STORE_SIZE && z < depth_mem[addr]) begin
            depth_mem[addr] = z;
            res.x = x;
            res.y = y;
            res.color = color;
            expected_pixels.push_back(res);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         screen_w = SCREEN_WIDTH_RESET;
         screen_h = SCREEN_ROWS_RESET;
         far_z = FAR_DEPTH_RESET;
         fill_store(FAR_DEPTH_RESET);
         expected_pixels.delete();
      end else begin
         // results are at least one word behind, so retire before predicting
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none, got cmd=%b %h x=%h y=%h c=%h",
                        $time, rsp_ch.is_command, rsp_ch.out_command, rsp_ch.out_x,
                        rsp_ch.out_y, rsp_ch.out_color);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("is_command", WORD_W'(want.is_command), WORD_W'(rsp_ch.is_command));
               check_field("out_command", want.command, rsp_ch.out_command);
               check_field("out_x", WORD_W'(want.x), WORD_W'(rsp_ch.out_x));
               check_field("out_y", WORD_W'(want.y), WORD_W'(rsp_ch.out_y));
               check_field("out_color", want.color, rsp_ch.out_color);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_SCREEN_WIDTH:  screen_w = csr_ch.data[DIM_W-1:0];
               CSR_SCREEN_ROWS:   screen_h = csr_ch.data[DIM_W-1:0];
               CSR_FAR_DEPTH:     far_z = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            depth_test(req_ch.opcode, req_ch.command_word, req_ch.pixel_x, req_ch.pixel_y,
                       req_ch.frag_depth, req_ch.frag_color);
      end
      outstanding <= expected_pixels.size();
   end

endmodule

// ----- tb/fragment_depth_test_tb.sv -----
// Top of the fragment depth test bench: clock, reset, stimulus on req_ch and csr_ch,
// a stalling receiver on rsp_ch and the verdict. Depends on fdt_pkg, the three
// channel interfaces, fragment_depth_test and fragment_depth_test_checker.

module fragment_depth_test_tb;
   import fdt_pkg::*;

   // spare register index, not mapped to any register
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int WORD_TARGET = 900;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   pending;
   int   words_sent = 0;
   int   used_w = MAX_WIDTH;
   int   used_h = MAX_HEIGHT;
   bit   req_burst = 1'b0;
   bit   rsp_burst = 1'b0;

   fdt_req_if req_ch ();
   fdt_rsp_if rsp_ch ();
   fdt_csr_if csr_ch ();

   fragment_depth_test i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   fragment_depth_test_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .error_count (mismatches),
      .outstanding (pending)
   );

   always #4 clock = ~clock;

   // Offer one word after a random gap and hold it until the block takes it.
   // Leave valid high on return so back-to-back words need no second assignment.
   task automatic push_word(input logic op, input logic [WORD_W-1:0] cmd,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [WORD_W-1:0] z, input logic [WORD_W-1:0] color);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= op;
      req_ch.command_word <= cmd;
      req_ch.pixel_x      <= x;
      req_ch.pixel_y      <= y;
      req_ch.frag_depth   <= z;
      req_ch.frag_color   <= color;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      words_sent++;
   endtask

   // Fragment: the command word is a don't-care, so randomize it.
   task automatic send_fragment(input int x, input int y, input logic [WORD_W-1:0] z);
      push_word(OP_FRAGMENT, $urandom(), COORD_W'(x), COORD_W'(y), z, $urandom());
   endtask

   // Command: the fragment fields are don't-cares, so randomize them.
   task automatic send_command(input logic [WORD_W-1:0] cmd);
      push_word(OP_COMMAND, cmd, COORD_W'($urandom()), COORD_W'($urandom()), $urandom(),
                $urandom());
   endtask

   // Hold csr valid high until the write is taken; caller drops valid afterwards.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
   endtask

   // Program the whole register file. Dimension writes carry random upper bits,
   // which the block must ignore. Optionally hit the unmapped index first.
   task automatic configure(input int w, input int h, input logic [WORD_W-1:0] far,
                            input bit touch_spare);
      if (touch_spare) write_reg(CSR_UNMAPPED, $urandom());
      write_reg(CSR_SCREEN_WIDTH, (WORD_W'($urandom()) & ~WORD_W'(9'h1FF)) | WORD_W'(w));
      write_reg(CSR_SCREEN_ROWS, (WORD_W'($urandom()) & ~WORD_W'(9'h1FF)) | WORD_W'(h));
      write_reg(CSR_FAR_DEPTH, far);
      csr_ch.valid <= 1'b0;
      used_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      used_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
   endtask

   // Drop valid, wait for every predicted result, then give a dropped fragment
   // still in the pipe time to retire.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Receiver: random stalls per result, stretches of none, and one long
   // hold-off so the output register fills and req_ch backs up.
   initial begin : rsp_sink
      int gap;
      int taken;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
         gap = rsp_burst ? 0 : $urandom_range(0, 6);
         if (taken == 150) gap = 400;
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int               sel;
      int               count;
      int               w;
      int               h;
      int               base_x;
      int               base_y;
      int               last_x;
      int               last_y;
      logic [WORD_W-1:0] last_z;
      logic [WORD_W-1:0] far;
      logic [WORD_W-1:0] z;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_FRAGMENT;
      req_ch.command_word <= '0;
      req_ch.pixel_x      <= '0;
      req_ch.pixel_y      <= '0;
      req_ch.frag_depth   <= '0;
      req_ch.frag_color   <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_SCREEN_WIDTH;
      csr_ch.data         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // csr is always ready, so program defaults while the post-reset clear runs
      configure(256, 256, FAR_DEPTH_RESET, 1'b1);

      send_fragment(0, 0, 32'h0000_1000);        // first hit, passes
      send_fragment(0, 0, 32'h0000_1000);        // equal depth, drop
      send_fragment(0, 0, 32'h0000_1001);        // farther, drop
      send_fragment(0, 0, 32'h0000_0FFF);        // nearer, passes
      send_fragment(255, 255, 32'hFFFF_FFFE);    // far corner, just under far
      send_fragment(1, 0, 32'hFFFF_FFFF);        // equal to the far depth, drop
      send_fragment(17, 3, 32'h0000_0000);       // nearest possible depth
      send_fragment(256, 0, 32'h0000_0000);      // off screen in x
      send_fragment(0, 256, 32'h0000_0000);      // off screen in y
      send_fragment(16'hFFFF, 16'hFFFF, 32'h0);  // coordinate extremes
      send_command(32'hFFFF_FFFF);               // new frame
      send_fragment(0, 0, 32'h0000_1000);        // passes again after clear
      drain();

      // zero-sized screen in either dimension drops everything
      configure(0, 256, FAR_DEPTH_RESET, 1'b0);
      send_fragment(5, 5, 32'h0);
      drain();
      configure(256, 0, FAR_DEPTH_RESET, 1'b0);
      send_fragment(5, 5, 32'h0);
      drain();

      // oversized dimensions clamp to the store size
      configure(511, 300, FAR_DEPTH_RESET, 1'b0);
      send_fragment(255, 255, 32'h0000_0010);
      send_fragment(256, 0, 32'h0000_0010);
      drain();

      // far depth of zero: after the clear nothing can be nearer
      configure(256, 256, 32'h0000_0000, 1'b0);
      send_command(32'h0000_0000);
      send_fragment(3, 3, 32'h0000_0000);
      drain();

      // one-pixel screen, after restoring the far depth through a clear
      configure(1, 1, FAR_DEPTH_RESET, 1'b0);
      send_fragment(0, 0, 32'h0000_0005);        // store still holds zero, drop
      send_command($urandom());
      send_fragment(0, 0, 32'h0000_0005);
      send_fragment(0, 1, 32'h0000_0001);
      send_fragment(1, 0, 32'h0000_0001);

      // ---- random part: phases of one setting each ----
      last_x = 0;
      last_y = 0;
      last_z = 32'h0;
      while (words_sent < WORD_TARGET) begin
         drain();
         case ($urandom_range(0, 7))
            0: begin w = 256; h = 256; end
            1: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
            2: begin w = $urandom_range(257, 511); h = $urandom_range(257, 511); end
            3: begin
               w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 256);
               h = (w == 0) ? $urandom_range(1, 256) : 0;
            end
            4: begin w = 1; h = $urandom_range(1, 256); end
            5: begin w = $urandom_range(1, 256); h = 1; end
            default: begin w = $urandom_range(1, 256); h = $urandom_range(1, 256); end
         endcase
         sel = $urandom_range(0, 7);
         far = (sel == 0) ? 32'h0 : (sel < 3) ? 32'hFFFF_FFFF : $urandom();
         configure(w, h, far, $urandom_range(0, 3) == 0);
         req_burst = ($urandom_range(0, 3) == 0);

         // a stale store under the new mapping is worth testing, so clear only sometimes
         if ($urandom_range(0, 1) == 0) send_command($urandom());

         base_x = (used_w > 4) ? $urandom_range(0, used_w - 4) : 0;
         base_y = (used_h > 4) ? $urandom_range(0, used_h - 4) : 0;
         count = $urandom_range(60, 120);
         repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
               send_command($urandom());
            end else if (sel < 10) begin
               // noise across the whole coordinate range
               send_fragment($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
            end else if (sel < 14) begin
               // last column or one past it
               send_fragment(used_w - 1 + $urandom_range(0, 1), base_y + $urandom_range(0, 3),
                             $urandom());
            end else if (sel < 18) begin
               // last row or one past it
               send_fragment(base_x + $urandom_range(0, 3), used_h - 1 + $urandom_range(0, 1),
                             $urandom());
            end else if (sel < 32) begin
               // replay the last fragment: equal depth if it passed
               send_fragment(last_x, last_y, last_z);
            end else begin
               // dense window so pixels are hit again and again
               last_x = base_x + $urandom_range(0, 3);
               last_y = base_y + $urandom_range(0, 3);
               z = ($urandom_range(0, 1) == 0) ? $urandom()
                                               : last_z - WORD_W'($urandom_range(0, 1000));
               last_z = z;
               send_fragment(last_x, last_y, z);
            end
         end
      end

      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: generous against a few clearing passes plus every word fully stalled.
   initial begin
      #24_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
